// File: hw/rtl/fdtp_pkg.sv
// Package for the 4D to 3D projection core: payload words and pipeline sideband.
// No dependencies; imported by every module of the block.
package fdtp_pkg;

	localparam int SqrtSteps = 32;
	localparam int DivSteps  = 33;
	localparam int DivLat    = DivSteps + 1;

	localparam logic [31:0] S32Max = 32'h7FFF_FFFF;
	localparam logic [31:0] S32Min = 32'h8000_0000;
	localparam logic [31:0] QOne   = 32'h0001_0000;

	typedef enum logic [1:0] {
		REG_MODE     = 2'd0,
		REG_DISTANCE = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic signed [31:0] in_w;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               degenerate;
		logic               clipped;
	} out_word_t;

	// carried alongside the square root
	typedef struct packed {
		logic               mode;
		logic signed [31:0] w;
		logic signed [31:0] view_dist;
		logic [2:0][62:0]   pmag;
		logic [2:0]         psign;
		logic [2:0]         neg;
		logic [2:0]         nz;
	} side_t;

	// carried alongside the dividers
	typedef struct packed {
		logic       degen;
		logic [2:0] qsign;
		logic [2:0] neg;
		logic [2:0] nz;
	} tag_t;

endpackage

// File: hw/rtl/fdtp_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// Depends on fdtp_pkg.
module fdtp_sqrt import fdtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] in_rad,
	input  logic        in_carry,
	input  side_t       in_side,
	output logic        out_valid,
	output logic [31:0] out_root,
	output logic        out_carry,
	output side_t       out_side
);

	logic        valid_sn [SqrtSteps];
	logic [63:0] rad_sn   [SqrtSteps];
	logic [34:0] rem_sn   [SqrtSteps];
	logic [31:0] root_sn  [SqrtSteps];
	logic        carry_sn [SqrtSteps];
	side_t       side_sn  [SqrtSteps];

	for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
		logic        v_in;
		logic [63:0] rad_in;
		logic [34:0] rem_in;
		logic [31:0] root_in;
		logic        carry_in;
		side_t       side_in;
		logic [34:0] acc;
		logic [34:0] trial;

		if (i == 0) begin : g_first
			assign v_in     = in_valid;
			assign rad_in   = in_rad;
			assign rem_in   = '0;
			assign root_in  = '0;
			assign carry_in = in_carry;
			assign side_in  = in_side;
		end else begin : g_next
			assign v_in     = valid_sn[i-1];
			assign rad_in   = rad_sn[i-1];
			assign rem_in   = rem_sn[i-1];
			assign root_in  = root_sn[i-1];
			assign carry_in = carry_sn[i-1];
			assign side_in  = side_sn[i-1];
		end

		assign acc   = {rem_in[32:0], rad_in[63:62]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[i] <= 1'b0;
			end else begin
				valid_sn[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_sn[i]   <= {rad_in[61:0], 2'b00};
			carry_sn[i] <= carry_in;
			side_sn[i]  <= side_in;
			if (acc >= trial) begin
				rem_sn[i]  <= acc - trial;
				root_sn[i] <= {root_in[30:0], 1'b1};
			end else begin
				rem_sn[i]  <= acc;
				root_sn[i] <= {root_in[30:0], 1'b0};
			end
		end
	end

	assign out_valid = valid_sn[SqrtSteps-1];
	assign out_root  = root_sn[SqrtSteps-1];
	assign out_carry = carry_sn[SqrtSteps-1];
	assign out_side  = side_sn[SqrtSteps-1];

endmodule

// File: hw/rtl/fdtp_div_lane.sv
// Pipelined unsigned restoring divider for one coordinate: 33 quotient bits
// plus an overflow flag for quotients of 2^33 and up. Depends on fdtp_pkg.
module fdtp_div_lane import fdtp_pkg::*; (
	input  logic        clk,
	input  logic [62:0] num,
	input  logic [33:0] den,
	output logic [32:0] quo,
	output logic        ovf
);

	logic [62:0] rem_sn [DivLat];
	logic [33:0] den_sn [DivLat];
	logic [32:0] quo_sn [DivLat];
	logic        ovf_sn [DivLat];

	always_ff @(posedge clk) begin
		rem_sn[0] <= num;
		den_sn[0] <= den;
		quo_sn[0] <= '0;
		ovf_sn[0] <= {4'b0, num} >= {den, 33'b0};
	end

	for (genvar k = 1; k < DivLat; k++) begin : g_step
		localparam int Bit = DivLat - 1 - k;
		logic [66:0] shifted;
		logic        take;

		assign shifted = {33'b0, den_sn[k-1]} << Bit;
		assign take    = {4'b0, rem_sn[k-1]} >= shifted;

		always_ff @(posedge clk) begin
			den_sn[k] <= den_sn[k-1];
			ovf_sn[k] <= ovf_sn[k-1];
			quo_sn[k] <= {quo_sn[k-1][31:0], take};
			rem_sn[k] <= take ? rem_sn[k-1] - shifted[62:0] : rem_sn[k-1];
		end
	end

	assign quo = quo_sn[DivLat-1];
	assign ovf = ovf_sn[DivLat-1];

endmodule

// File: hw/rtl/four_d_to_three_d_projection_core.sv
// Top level of the 4D to 3D projection core: perspective or stereographic.
// Depends on fdtp_pkg, fdtp_sqrt and fdtp_div_lane.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------
//  input    | start, busy, in_word                      | start && !busy
//  result   | done, out_word                            | done, one cycle
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// One word per cycle in, one per cycle out; busy is never raised.
// The pipeline depth is set by the bit-per-stage square
// root and the bit-per-stage quotient pipelines.
// Reset clears the valid bits and the config registers; no clearing pass.
module four_d_to_three_d_projection_core import fdtp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    in_word,
	output logic        done,
	output out_word_t   out_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic               mode_q;
	logic signed [31:0] dist_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			dist_q <= 32'sd131072;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:     mode_q <= cfg_data[0];
				REG_DISTANCE: dist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: capture
	logic               valid_s1;
	in_word_t           word_s1;
	logic               mode_s1;
	logic signed [31:0] dist_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= in_word;
		mode_s1 <= mode_q;
		dist_s1 <= dist_q;
	end

	// s2: magnitudes, squares, numerator products
	logic [3:0][31:0] mag;
	logic [31:0]      scale_mag;
	logic             scale_neg;
	logic [3:0]       neg;

	assign neg = {word_s1.in_w[31], word_s1.in_z[31], word_s1.in_y[31], word_s1.in_x[31]};
	assign mag[0] = neg[0] ? 32'(-word_s1.in_x) : word_s1.in_x;
	assign mag[1] = neg[1] ? 32'(-word_s1.in_y) : word_s1.in_y;
	assign mag[2] = neg[2] ? 32'(-word_s1.in_z) : word_s1.in_z;
	assign mag[3] = neg[3] ? 32'(-word_s1.in_w) : word_s1.in_w;
	assign scale_neg = !mode_s1 && dist_s1[31];
	assign scale_mag = mode_s1 ? QOne : (scale_neg ? 32'(-dist_s1) : dist_s1);

	logic             valid_s2;
	logic [3:0][63:0] sq_s2;
	side_t            side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			sq_s2[i] <= mag[i] * mag[i];
		end
		for (int i = 0; i < 3; i++) begin
			side_s2.pmag[i]  <= 63'(mag[i] * scale_mag);
			side_s2.psign[i] <= neg[i] ^ scale_neg;
			side_s2.nz[i]    <= mag[i] != 32'd0;
		end
		side_s2.neg       <= neg[2:0];
		side_s2.mode      <= mode_s1;
		side_s2.w         <= word_s1.in_w;
		side_s2.view_dist <= dist_s1;
	end

	// s3, s4: sum of squares
	logic        valid_s3, valid_s4;
	logic [63:0] pair_a_s3, pair_b_s3;
	logic [64:0] sum_s4;
	side_t       side_s3, side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		pair_a_s3 <= sq_s2[0] + sq_s2[1];
		pair_b_s3 <= sq_s2[2] + sq_s2[3];
		side_s3   <= side_s2;
		sum_s4    <= {1'b0, pair_a_s3} + {1'b0, pair_b_s3};
		side_s4   <= side_s3;
	end

	logic        sq_valid;
	logic [31:0] sq_root;
	logic        sq_carry;
	side_t       sq_side;

	fdtp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_rad    (sum_s4[63:0]),
		.in_carry  (sum_s4[64]),
		.in_side   (side_s4),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_carry (sq_carry),
		.out_side  (sq_side)
	);

	// s5: denominator
	logic [32:0] norm;
	assign norm = sq_carry ? 33'h1_0000_0000 :
	              (sq_root == 32'd0) ? {1'b0, QOne} : {1'b0, sq_root};

	logic               valid_s5;
	logic signed [34:0] den_s5;
	side_t              side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= sq_side;
		if (sq_side.mode) begin
			den_s5 <= $signed({2'b00, norm}) - 35'(sq_side.w);
		end else begin
			den_s5 <= 35'(sq_side.view_dist) - 35'(sq_side.w);
		end
	end

	// s6: denominator magnitude and zero test
	logic               valid_s6;
	logic [33:0]        den_mag_s6;
	logic [2:0][62:0]   num_s6;
	tag_t               tag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		den_mag_s6   <= den_s5[34] ? 34'(-den_s5) : 34'(den_s5);
		num_s6       <= side_s5.pmag;
		tag_s6.degen <= den_s5 == 35'sd0;
		tag_s6.qsign <= side_s5.psign ^ {3{den_s5[34]}};
		tag_s6.neg   <= side_s5.neg;
		tag_s6.nz    <= side_s5.nz;
	end

	logic [2:0][32:0] quo;
	logic [2:0]       ovf;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		fdtp_div_lane u_div (
			.clk (clk),
			.num (num_s6[i]),
			.den (den_mag_s6),
			.quo (quo[i]),
			.ovf (ovf[i])
		);
	end

	logic valid_dn [DivLat];
	tag_t tag_dn   [DivLat];

	for (genvar k = 0; k < DivLat; k++) begin : g_tag
		logic v_in;
		tag_t t_in;
		if (k == 0) begin : g_first
			assign v_in = valid_s6;
			assign t_in = tag_s6;
		end else begin : g_next
			assign v_in = valid_dn[k-1];
			assign t_in = tag_dn[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_dn[k] <= 1'b0;
			end else begin
				valid_dn[k] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			tag_dn[k] <= t_in;
		end
	end

	// final: sign, saturation
	tag_t             tag_f;
	logic [2:0][31:0] res;
	logic [2:0]       sat;

	assign tag_f = tag_dn[DivLat-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = '0;
			sat[i] = 1'b0;
			if (tag_f.degen) begin
				sat[i] = tag_f.nz[i];
				if (tag_f.nz[i]) begin
					res[i] = tag_f.neg[i] ? S32Min : S32Max;
				end
			end else if (!tag_f.qsign[i]) begin
				if (ovf[i] || quo[i][32:31] != 2'b00) begin
					res[i] = S32Max;
					sat[i] = 1'b1;
				end else begin
					res[i] = quo[i][31:0];
				end
			end else begin
				if (ovf[i] || quo[i] > {1'b0, S32Min}) begin
					res[i] = S32Min;
					sat[i] = 1'b1;
				end else begin
					res[i] = 32'(-quo[i]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_dn[DivLat-1];
		end
	end

	always_ff @(posedge clk) begin
		out_word.out_x      <= res[0];
		out_word.out_y      <= res[1];
		out_word.out_z      <= res[2];
		out_word.degenerate <= tag_f.degen;
		out_word.clipped    <= |sat;
	end

endmodule

// File: bench/tb.sv
// Testbench for four_d_to_three_d_projection_core: directed and random points in both modes.
// It predicts every result with its own model of the projection and checks the results in order.
// Depends on fdtp_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb;
	import fdtp_pkg::*;

	class projection_scoreboard;
		out_word_t pending[$];
		logic      mode;
		longint    view_dist;
		int        errors;

		function new();
			mode      = 1'b0;
			view_dist = 131072;
			errors    = 0;
		endfunction

		function automatic longint unsigned int_root(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function automatic longint clamp32(longint v, ref logic clip);
			if (v > 64'sd2147483647) begin
				clip = 1'b1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				clip = 1'b1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function void note(in_word_t w);
			longint          c[4];
			longint          r[3];
			longint          num;
			longint          den;
			longint unsigned mag;
			logic [65:0]     sumsq;
			longint unsigned n;
			logic            clip;
			out_word_t       e;
			c[0] = longint'(w.in_x);
			c[1] = longint'(w.in_y);
			c[2] = longint'(w.in_z);
			c[3] = longint'(w.in_w);
			clip = 1'b0;
			if (mode) begin
				sumsq = '0;
				for (int i = 0; i < 4; i++) begin
					mag = (c[i] < 0) ? longint'(-c[i]) : c[i];
					sumsq += 66'(mag) * 66'(mag);
				end
				if (sumsq >= (66'd1 << 64))
					n = 64'd1 << 32;
				else
					n = int_root(sumsq[63:0]);
				if (n == 0)
					n = 64'd65536;
				den = longint'(n) - c[3];
				num = 65536;
			end else begin
				den = view_dist - c[3];
				num = view_dist;
			end
			e.degenerate = (den == 0);
			for (int i = 0; i < 3; i++) begin
				if (den == 0) begin
					if (c[i] > 0) begin
						r[i] = 64'sd2147483647;
						clip = 1'b1;
					end else if (c[i] < 0) begin
						r[i] = -64'sd2147483648;
						clip = 1'b1;
					end else begin
						r[i] = 0;
					end
				end else begin
					r[i] = clamp32((c[i] * num) / den, clip);
				end
			end
			e.out_x   = r[0][31:0];
			e.out_y   = r[1][31:0];
			e.out_z   = r[2][31:0];
			e.clipped = clip;
			pending.push_back(e);
		endfunction

		function void check(out_word_t got);
			out_word_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, actual %h", $time, got);
				return;
			end
			e = pending.pop_front();
			if (got.out_x !== e.out_x || got.out_y !== e.out_y || got.out_z !== e.out_z ||
			    got.degenerate !== e.degenerate || got.clipped !== e.clipped) begin
				errors++;
				$display("%0t: mismatch, expected %h actual %h", $time, e, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    in_word;
	logic        done;
	out_word_t   out_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	projection_scoreboard sb;
	int  cycles;
	bit  no_gaps;

	four_d_to_three_d_projection_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.in_word  (in_word),
		.done     (done),
		.out_word (out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note(in_word);
		if (arst_n && done)
			sb.check(out_word);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
	                          logic [31:0] w);
		if (!no_gaps) begin
			while ($urandom_range(99) < 17) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start   <= 1'b1;
		in_word <= {x, y, z, w};
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MODE)
			sb.mode = data[0];
		else
			sb.view_dist = longint'(signed'(data));
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3, 4:    return 32'($signed($urandom_range(524288)) - 262144);
			5:       return '0;
			6:       return S32Max;
			7:       return S32Min;
			default: return 32'($signed($urandom_range(16384)) - 8192) <<< 8;
		endcase
	endfunction

	task automatic random_points(int count);
		logic [31:0] x, y, z, w;
		for (int k = 0; k < count; k++) begin
			x = pick_coord();
			y = pick_coord();
			z = pick_coord();
			w = pick_coord();
			case ($urandom_range(9))
				0: w = sb.mode ? w : sb.view_dist[31:0];
				1: w = sb.mode ? w :
				       sb.view_dist[31:0] + ($urandom_range(1) ? 32'd1 : -32'd1);
				2: begin
					if (sb.mode) begin
						x = '0;
						y = '0;
						z = '0;
					end
				end
				default: ;
			endcase
			send_point(x, y, z, w);
		end
	endtask

	initial begin
		sb        = new();
		cycles    = 0;
		no_gaps   = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		in_word   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// perspective at reset distance
		send_point(32'd65536, 32'd131072, -32'd65536, 32'd0);
		send_point(S32Max, S32Min, 32'd0, 32'd131072);
		send_point(32'd5, -32'd5, 32'd0, 32'd131072);
		send_point(S32Max, S32Max, S32Min, 32'd131071);
		send_point(S32Min, S32Max, 32'd1, S32Min);
		send_point(S32Max, S32Min, S32Max, S32Max);
		send_point(32'd0, 32'd0, 32'd0, 32'd0);
		send_point(32'hFFFF_FFFF, 32'd1, 32'h1234_5678, 32'd131073);
		drain();
		write_reg(REG_MODE, 32'hFFFF_FFFF);
		send_point(32'd0, 32'd0, 32'd0, 32'd0);
		send_point(S32Min, S32Min, S32Min, S32Min);
		send_point(32'd0, 32'd0, 32'd0, 32'd65536);
		send_point(32'd0, 32'd0, 32'd0, S32Max);
		send_point(32'd0, 32'd0, 32'd0, S32Min);
		send_point(32'd196608, 32'd262144, 32'd0, 32'd0);
		send_point(S32Max, S32Max, S32Max, S32Max);
		send_point(32'd1, 32'd0, 32'd0, 32'd0);
		send_point(-32'd1, 32'd0, 32'd0, 32'd1);
		send_point(32'd0, 32'd1, -32'd1, 32'd65536);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin write_reg(REG_MODE, 32'd0); write_reg(REG_DISTANCE, 32'd131072); end
				1: write_reg(REG_MODE, 32'h8000_0001);
				2: begin write_reg(REG_MODE, 32'hFFFF_FFFE); write_reg(REG_DISTANCE, '0); end
				3: write_reg(REG_DISTANCE, S32Max);
				4: write_reg(REG_DISTANCE, S32Min);
				5: write_reg(REG_DISTANCE, $urandom);
				6: write_reg(REG_DISTANCE, $urandom_range(65536 * 64));
				7: write_reg(REG_MODE, 32'd1);
				default: begin write_reg(REG_MODE, 32'd0); write_reg(REG_DISTANCE, 32'd1); end
			endcase
			no_gaps = (ph == 4);
			random_points(205);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/fdtp_pkg.sv
hw/rtl/fdtp_sqrt.sv
hw/rtl/fdtp_div_lane.sv
hw/rtl/four_d_to_three_d_projection_core.sv
bench/tb.sv
